### hw/rtl/mbdd_pkg.sv
// Shared constants and register indexes for the multibyte delimiter deframer.
`timescale 1ns / 1ps
`default_nettype none

package mbdd_pkg;

   localparam int DATA_W     = 8;
   localparam int MSG_LEN_W  = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 1;
   localparam int LEN_W      = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DELIM_BYTES  = 1'b0,
      REG_DELIM_LENGTH = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] DELIM_BYTES_RESET  = 64'd10;
   localparam logic [LEN_W-1:0]      DELIM_LENGTH_RESET = 4'd1;

endpackage

`default_nettype wire

### hw/rtl/mbdd_req_if.sv
// Input byte channel of the deframer.
`timescale 1ns / 1ps
`default_nettype none

interface mbdd_req_if;
   logic                          valid;
   logic                          ready;
   logic [mbdd_pkg::DATA_W-1:0]   data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/mbdd_rsp_if.sv
// Result channel of the deframer: payload bytes and end-of-message markers.
`timescale 1ns / 1ps
`default_nettype none

interface mbdd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mbdd_pkg::DATA_W-1:0]      payload_byte;
   logic                             has_byte;
   logic                             end_of_message;
   logic [mbdd_pkg::MSG_LEN_W-1:0]   message_length;

   modport source (output valid, output payload_byte, output has_byte,
                   output end_of_message, output message_length, input ready);
   modport sink   (input valid, input payload_byte, input has_byte,
                   input end_of_message, input message_length, output ready);
endinterface

`default_nettype wire

### hw/rtl/multibyte_delimiter_deframer.sv
// Top level of the multibyte delimiter deframer.
`timescale 1ns / 1ps
`default_nettype none

// Splits a byte stream into messages ended by a programmable delimiter of 1 to
// MAX_DELIMITER bytes (csr index 0: pattern, first byte in bits 7:0; index 1:
// length). Each accepted byte enters a pending window; once the window holds
// the delimiter length, every item yields exactly one result: an end-of-message
// marker with the saturated message length when the oldest bytes equal the
// delimiter, else the oldest byte as payload. Delimiter bytes are stripped and
// matching restarts right after a match. One item is accepted per cycle; its
// result appears in the result register on the next cycle. The input stalls
// only while that register holds a result the sink has not taken. Program the
// registers only while the block is idle.
module multibyte_delimiter_deframer #(
   parameter int MAX_DELIMITER = 8,
   parameter int LENGTH_BITS   = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   mbdd_req_if.sink                                req_stream,
   mbdd_rsp_if.source                              rsp_stream,
   input  wire logic                               csr_write_en,
   input  wire logic [mbdd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mbdd_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int DW    = mbdd_pkg::DATA_W;
   localparam int LW    = mbdd_pkg::LEN_W;
   localparam int MW    = mbdd_pkg::MSG_LEN_W;
   localparam int PW    = MAX_DELIMITER * DW;
   localparam int CNT_W = $clog2(MAX_DELIMITER + 1);
   localparam int EXT_W = (LENGTH_BITS > MW) ? LENGTH_BITS : MW;

   // configuration
   logic [PW-1:0]          delim_ff;
   logic [LW-1:0]          dlen_ff;
   logic [LW-1:0]          act_len;

   // window state
   logic [DW-1:0]          win_ff  [MAX_DELIMITER];
   logic [DW-1:0]          win_app [MAX_DELIMITER];
   logic [DW-1:0]          win_in  [MAX_DELIMITER];
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       cnt_app;
   logic [CNT_W-1:0]       cnt_in;
   logic [LENGTH_BITS-1:0] len_cnt_ff;
   logic [LENGTH_BITS-1:0] len_cnt_in;
   logic [EXT_W-1:0]       len_ext;
   logic [MW-1:0]          msg_len;

   // result register
   logic                   rsp_valid_ff;
   logic [DW-1:0]          pay_ff;
   logic                   has_ff;
   logic                   eom_ff;
   logic [MW-1:0]          mlen_ff;

   logic                   req_ready;
   logic                   take;
   logic                   full;
   logic                   match;
   logic                   load;

   assign req_ready        = !rsp_valid_ff || rsp_stream.ready;
   assign req_stream.ready = req_ready;
   assign take             = req_stream.valid && req_ready;

   always_comb begin
      if (dlen_ff == '0) begin
         act_len = LW'(1);
      end else if (dlen_ff > LW'(MAX_DELIMITER)) begin
         act_len = LW'(MAX_DELIMITER);
      end else begin
         act_len = dlen_ff;
      end
   end

   // append, compare and drop
   always_comb begin
      for (int k = 0; k < MAX_DELIMITER; k++) begin
         win_app[k] = (CNT_W'(k) == cnt_ff) ? req_stream.data_byte : win_ff[k];
      end
      cnt_app = cnt_ff + CNT_W'(1);
      full    = LW'(cnt_app) >= act_len;
      match   = 1'b1;
      for (int k = 0; k < MAX_DELIMITER; k++) begin
         if (LW'(k) < act_len && win_app[k] != delim_ff[DW*k +: DW]) begin
            match = 1'b0;
         end
      end

      len_ext = EXT_W'(len_cnt_ff);
      msg_len = (len_ext > EXT_W'({MW{1'b1}})) ? {MW{1'b1}} : len_ext[MW-1:0];

      win_in     = win_app;
      cnt_in     = cnt_app;
      len_cnt_in = len_cnt_ff;
      if (full && match) begin
         for (int k = 0; k < MAX_DELIMITER; k++) begin
            win_in[k] = '0;
            for (int s = 1; s <= MAX_DELIMITER; s++) begin
               if (LW'(s) == act_len && k + s < MAX_DELIMITER) begin
                  win_in[k] = win_app[k + s];
               end
            end
         end
         cnt_in     = cnt_app - CNT_W'(act_len);
         len_cnt_in = '0;
      end else if (full) begin
         for (int k = 0; k < MAX_DELIMITER; k++) begin
            win_in[k] = (k + 1 < MAX_DELIMITER) ? win_app[k + 1] : '0;
         end
         cnt_in = cnt_app - CNT_W'(1);
         if (len_cnt_ff != '1) begin
            len_cnt_in = len_cnt_ff + LENGTH_BITS'(1);
         end
      end
   end

   assign load = take && full;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff     <= mbdd_pkg::DELIM_BYTES_RESET[PW-1:0];
         dlen_ff      <= mbdd_pkg::DELIM_LENGTH_RESET;
         cnt_ff       <= '0;
         len_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (mbdd_pkg::csr_index_type'(csr_index))
               mbdd_pkg::REG_DELIM_BYTES:  delim_ff <= csr_write_data[PW-1:0];
               mbdd_pkg::REG_DELIM_LENGTH: dlen_ff  <= csr_write_data[LW-1:0];
            endcase
         end
         if (take) begin
            cnt_ff     <= cnt_in;
            len_cnt_ff <= len_cnt_in;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_stream.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         win_ff <= win_in;
      end
      if (load) begin
         pay_ff  <= match ? '0 : win_app[0];
         has_ff  <= !match;
         eom_ff  <= match;
         mlen_ff <= match ? msg_len : '0;
      end
   end

   assign rsp_stream.valid          = rsp_valid_ff;
   assign rsp_stream.payload_byte   = pay_ff;
   assign rsp_stream.has_byte       = has_ff;
   assign rsp_stream.end_of_message = eom_ff;
   assign rsp_stream.message_length = mlen_ff;

`ifndef SYNTHESIS
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (has_ff != eom_ff))
      else $error("result is neither payload nor marker exclusively");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DELIMITER - 1))
      else $error("pending count exceeds window");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stream.ready) |-> !req_stream.ready)
      else $error("input taken while result held");

   a_marker_clears: assert property (@(posedge clock) disable iff (reset)
      (load && match) |=> (len_cnt_ff == '0 && eom_ff))
      else $error("length counter not cleared by marker");
`endif

endmodule

`default_nettype wire
